// ===== rtl/atoc_pkg.sv =====
// ----------------------------------------------------------------------------
// atoc_pkg: shared types and constants
// Payload structs, status and operator codes, controller command/status.
// ----------------------------------------------------------------------------
package atoc_pkg;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned StatusWidth = 3;

  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharStar  = 8'h2A;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam logic [63:0] ArgLimit = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_OP   = 3'd1,
    ST_NO_ARG2 = 3'd2,
    ST_DIV0    = 3'd3,
    ST_TOO_BIG = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic [2:0]         status;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic take_char;   // accumulate one character
    logic start_eval;  // line ended: start final operation
    logic step_eval;   // one iteration of multiply/divide
    logic load_out;    // latch result into output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic needs_iter;  // final op is mul or div with a valid result
    logic iter_last;   // iteration counter at its last step
  } dp_sts_t;

endpackage

// ===== rtl/atoc_datapath.sv =====
// ----------------------------------------------------------------------------
// atoc_datapath: accumulators and shared shift-add / restoring-divide unit
// Builds both arguments digit by digit and evaluates the result at line end.
// ----------------------------------------------------------------------------
module atoc_datapath
  import atoc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  dp_cmd_t   cmd_i,
  output dp_sts_t   sts_o,
  output out_item_t out_item_o
);

  logic [63:0] first_q, first_d, second_q, second_d;
  logic        first_done_q, first_done_d;
  logic        op_seen_q, op_seen_d;
  op_e         op_q, op_d;
  logic        has_dig_q, has_dig_d;
  logic        big_q, big_d;

  // iterative unit
  logic [63:0] acc_q, acc_d;    // product / remainder
  logic [63:0] mq_q, mq_d;      // multiplier / quotient
  logic [63:0] opnd_q, opnd_d;  // multiplicand / divisor
  logic [5:0]  cnt_q, cnt_d;
  status_e     pend_st_q, pend_st_d;
  logic [63:0] pend_val_q, pend_val_d;
  out_item_t   out_q, out_d;

  logic        is_digit;
  logic [3:0]  dig;
  logic        is_op;
  op_e         op_code;

  assign is_digit = (in_item_i.char_code >= CharZero) && (in_item_i.char_code <= CharNine);
  assign dig      = 4'(in_item_i.char_code - CharZero);

  always_comb begin
    is_op   = 1'b1;
    op_code = OP_ADD;
    case (in_item_i.char_code)
      CharPlus:  op_code = OP_ADD;
      CharMinus: op_code = OP_SUB;
      CharStar:  op_code = OP_MUL;
      CharSlash: op_code = OP_DIV;
      default:   is_op = 1'b0;
    endcase
  end

  // acc*10+d must stay <= ArgLimit, i.e. acc <= (ArgLimit-d)/10.
  // ArgLimit ends in 7, so the bound is one lower for digits 8 and 9.
  function automatic logic [63:0] limit_for(input logic [3:0] d);
    limit_for = (d > 4'd7) ? (ArgLimit / 64'd10) - 64'd1 : ArgLimit / 64'd10;
  endfunction

  logic [63:0] lim;
  logic        f_push, s_push, f_ovf, s_ovf;
  assign lim    = limit_for(dig);
  assign f_push = is_digit && !first_done_q;
  assign s_push = is_digit && op_seen_q;
  assign f_ovf  = first_q > lim;
  assign s_ovf  = second_q > lim;

  // restoring division step
  logic [64:0] rem_sh, rem_sub;
  assign rem_sh  = {acc_q, mq_q[63]};
  assign rem_sub = rem_sh - {1'b0, opnd_q};

  always_comb begin
    first_d      = first_q;
    second_d     = second_q;
    first_done_d = first_done_q;
    op_seen_d    = op_seen_q;
    op_d         = op_q;
    has_dig_d    = has_dig_q;
    big_d        = big_q;
    acc_d        = acc_q;
    mq_d         = mq_q;
    opnd_d       = opnd_q;
    cnt_d        = cnt_q;
    pend_st_d    = pend_st_q;
    pend_val_d   = pend_val_q;
    out_d        = out_q;

    if (cmd_i.take_char) begin
      if (is_digit) begin
        if (f_push) begin
          if (f_ovf) big_d = 1'b1;
          else first_d = (first_q << 3) + (first_q << 1) + 64'(dig);
        end
        if (s_push) begin
          if (s_ovf) big_d = 1'b1;
          else second_d = (second_q << 3) + (second_q << 1) + 64'(dig);
        end
        has_dig_d = 1'b1;
      end else begin
        first_done_d = 1'b1;
        if (is_op) begin
          if (!op_seen_q) has_dig_d = 1'b0;
          op_seen_d = 1'b1;
          op_d      = op_code;
        end
      end
    end

    if (cmd_i.start_eval) begin
      // decide status from the state just updated by this character
      pend_val_d = '0;
      if (!op_seen_d)       pend_st_d = has_dig_d ? ST_NO_OP : ST_NO_ARG2;
      else if (!has_dig_d)  pend_st_d = ST_NO_ARG2;
      else if (big_d)       pend_st_d = ST_TOO_BIG;
      else begin
        pend_st_d = ST_OK;
        unique case (op_d)
          OP_ADD: pend_val_d = first_d + second_d;
          OP_SUB: pend_val_d = first_d - second_d;
          OP_MUL: ;
          OP_DIV: if (second_d == '0) pend_st_d = ST_DIV0;
          default: ;
        endcase
      end
      acc_d  = '0;
      mq_d   = (op_d == OP_MUL) ? second_d : first_d;
      opnd_d = (op_d == OP_MUL) ? first_d : second_d;
      cnt_d  = '0;
      // line consumed: clear accumulators
      first_d = '0; second_d = '0; first_done_d = 1'b0; op_seen_d = 1'b0;
      has_dig_d = 1'b0; big_d = 1'b0;
    end

    if (cmd_i.step_eval) begin
      if (op_q == OP_MUL) begin
        // LSB-first shift-add, low 64 bits kept
        if (mq_q[0]) acc_d = acc_q + opnd_q;
        mq_d   = mq_q >> 1;
        opnd_d = opnd_q << 1;
      end else begin
        if (!rem_sub[64]) begin
          acc_d = rem_sub[63:0];
          mq_d  = {mq_q[62:0], 1'b1};
        end else begin
          acc_d = rem_sh[63:0];
          mq_d  = {mq_q[62:0], 1'b0};
        end
      end
      cnt_d = cnt_q + 6'd1;
    end

    if (cmd_i.load_out) begin
      out_d.status = pend_st_q;
      if (pend_st_q != ST_OK)      out_d.value = '0;
      else if (op_q == OP_MUL)     out_d.value = acc_q;
      else if (op_q == OP_DIV)     out_d.value = mq_q;
      else                         out_d.value = pend_val_q;
    end
  end

  // op_q must survive the line clear until evaluation ends
  op_e op_hold_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0; second_q <= '0; first_done_q <= 1'b0; op_seen_q <= 1'b0;
      op_hold_q <= OP_ADD; has_dig_q <= 1'b0; big_q <= 1'b0; cnt_q <= '0;
      pend_st_q <= ST_OK;
    end else begin
      first_q <= first_d; second_q <= second_d; first_done_q <= first_done_d;
      op_seen_q <= op_seen_d; op_hold_q <= cmd_i.start_eval ? OP_ADD : op_d;
      has_dig_q <= has_dig_d; big_q <= big_d; cnt_q <= cnt_d;
      pend_st_q <= pend_st_d;
    end
  end

  // evaluation operator latched at line end
  op_e eval_op_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) eval_op_q <= OP_ADD;
    else if (cmd_i.start_eval) eval_op_q <= op_d;
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; mq_q <= mq_d; opnd_q <= opnd_d;
    pend_val_q <= pend_val_d; out_q <= out_d;
  end

  // op_q during accumulation is op_hold_q; during evaluation eval_op_q
  logic evaluating_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) evaluating_q <= 1'b0;
    else if (cmd_i.start_eval) evaluating_q <= 1'b1;
    else if (cmd_i.load_out) evaluating_q <= 1'b0;
  end
  assign op_q = evaluating_q ? eval_op_q : op_hold_q;

  assign sts_o.needs_iter = (pend_st_q == ST_OK) &&
                            ((eval_op_q == OP_MUL) || (eval_op_q == OP_DIV));
  assign sts_o.iter_last  = (cnt_q == 6'd63);
  assign out_item_o       = out_q;

endmodule

// ===== rtl/atoc_ctrl.sv =====
// ----------------------------------------------------------------------------
// atoc_ctrl: sequencing controller
// Takes characters, runs the 64-step final operation for mul/div, holds the output item.
// ----------------------------------------------------------------------------
module atoc_ctrl
  import atoc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    line_end_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_ACC  = 4'b0001,
    S_CHK  = 4'b0010,
    S_ITER = 4'b0100,
    S_LOAD = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   take;

  // out register frees when taken; accumulation carries on meanwhile
  assign in_ready_o = (state_q == S_ACC) && !(line_end_i && out_valid_q && !out_ready_i);
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_ACC: begin
        cmd_o.take_char = take;
        if (take && line_end_i) begin
          cmd_o.start_eval = 1'b1;
          state_d = S_CHK;
        end
      end
      S_CHK:  state_d = sts_i.needs_iter ? S_ITER : S_LOAD;
      S_ITER: begin
        cmd_o.step_eval = 1'b1;
        if (sts_i.iter_last) state_d = S_LOAD;
      end
      S_LOAD: begin
        if (!out_valid_d) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_ACC;
        end
      end
      default: state_d = S_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ACC;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_end_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && line_end_i) |=> (state_q == S_CHK))
    else $error("line end did not start evaluation");
  a_no_clobber: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_o.load_out)
    else $error("held output overwritten");
  a_iter_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step_eval |-> (state_q == S_ITER))
    else $error("step outside iteration");

endmodule

// ===== rtl/ascii_two_operand_calculator_unit.sv =====
// ----------------------------------------------------------------------------
// ascii_two_operand_calculator_unit: ASCII two-operand calculator
// Parses one expression line character by character; gives one result item.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid_i/ready_o  | in_item_i  (char_code, line_end)
// out     | output    | out_valid_o/ready_i | out_item_o (value, status)
//
// Ordinary characters are accepted back to back.
// Line end: for add/sub/error the result passes the check state, then the load;
// for multiply or divide, the check state, then 64 passes through the
// shared shift-add / restoring-divide unit, then the load.
// Input is held off from a line end until its result is loaded (next item in
// the cycle after), and a line end is held off while a previous result waits.
// Reset (rst_ni low, async) clears all line state and empties the output.
// ----------------------------------------------------------------------------
module ascii_two_operand_calculator_unit
  import atoc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  atoc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .line_end_i  (in_item_i.line_end),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  atoc_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_item_o (out_item_o)
  );

endmodule
